[rtl/online_dfs_maze_explorer_assert.svh]
// Assertion macros for the maze explorer RTL.
// Each macro expects signals named clk and rst in the scope where it is used.
`ifndef ONLINE_DFS_MAZE_EXPLORER_ASSERT_SVH
`define ONLINE_DFS_MAZE_EXPLORER_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ODME_ASSERT_SAME(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("odme check failed");

// The consequent must hold in the cycle after the antecedent.
`define ODME_ASSERT_NEXT(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("odme check failed");

`endif

[rtl/odme_pkg.sv]
// Shared types and constants for the online maze explorer.
// Used by the interfaces, the cell update logic and the top level.
package odme_pkg;

  // Width of a cell index and reset value of the goal register.
  localparam int CELL_W = 10;
  localparam logic [CELL_W-1:0] GOAL_RESET = 10'd1023;

  // Move codes: one-hot for a move, zero for stop.
  localparam logic [3:0] DIR_STOP  = 4'd0;
  localparam logic [3:0] DIR_LEFT  = 4'd1;
  localparam logic [3:0] DIR_UP    = 4'd2;
  localparam logic [3:0] DIR_RIGHT = 4'd4;
  localparam logic [3:0] DIR_DOWN  = 4'd8;

  // Two-bit direction codes kept in the backtrack queue.
  localparam logic [1:0] CODE_LEFT  = 2'd0;
  localparam logic [1:0] CODE_UP    = 2'd1;
  localparam logic [1:0] CODE_RIGHT = 2'd2;
  localparam logic [1:0] CODE_DOWN  = 2'd3;

  // Result status codes.
  localparam logic [1:0] STAT_NEW   = 2'd0;
  localparam logic [1:0] STAT_BACK  = 2'd1;
  localparam logic [1:0] STAT_GOAL  = 2'd2;
  localparam logic [1:0] STAT_NOSOL = 2'd3;

  // Largest number of backtrack entries per cell.
  localparam logic [2:0] QUEUE_DEPTH = 3'd4;

  // Sequencer states.
  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_REDUCE,
    S_READ,
    S_UPDATE
  } state_t;

  // One word of the per-cell table.
  typedef struct packed {
    logic       visited;
    logic [3:0] untried;
    logic [7:0] queue;
    logic [2:0] count;
  } entry_t;

  // Decision made for one cell visit.
  typedef struct packed {
    logic [3:0] move;
    logic [1:0] status;
    logic       record;
  } decision_t;

endpackage

[rtl/odme_ifs.sv]
// Valid/ready channel interfaces of the maze explorer.
// Depends on odme_pkg for the cell index width.
interface odme_req_if;
  logic                        valid;
  logic                        ready;
  logic [odme_pkg::CELL_W-1:0] cell_req;
  logic [3:0]                  open_mask;
  modport source (output valid, output cell_req, output open_mask, input ready);
  modport sink (input valid, input cell_req, input open_mask, output ready);
endinterface

interface odme_rsp_if;
  logic       valid;
  logic       ready;
  logic [3:0] move_dir;
  logic [1:0] status;
  modport source (output valid, output move_dir, output status, input ready);
  modport sink (input valid, input move_dir, input status, output ready);
endinterface

interface odme_cfg_if;
  logic                        valid;
  logic                        ready;
  logic [odme_pkg::CELL_W-1:0] goal_cell;
  modport source (output valid, output goal_cell, input ready);
  modport sink (input valid, input goal_cell, output ready);
endinterface

[rtl/odme_cell_update.sv]
// Decision logic for one cell visit: backtrack enqueue, move choice, dequeue.
// Depends on odme_pkg for the table entry and decision types.
module odme_cell_update (
  input  odme_pkg::entry_t    entry_in,
  input  logic [3:0]          open_mask,
  input  logic                has_prev,
  input  logic [3:0]          prev_dir,
  output odme_pkg::entry_t    entry_out,
  output odme_pkg::decision_t decision
);

  logic [3:0] untried;
  logic [2:0] count;
  logic [7:0] queue;
  logic [1:0] rev;
  logic       rev_ok;
  logic       found;
  logic [2:0] count_q;
  logic [7:0] queue_q;
  logic [3:0] pick;

  // A first visit takes the open directions as the untried set.
  always_comb begin
    untried = entry_in.visited ? entry_in.untried : open_mask;
    count = (entry_in.count > odme_pkg::QUEUE_DEPTH) ? odme_pkg::QUEUE_DEPTH
                                                      : entry_in.count;
    queue = entry_in.queue;
  end

  // Reverse of the previous move; only a one-hot move has a reverse.
  always_comb begin
    rev    = odme_pkg::CODE_LEFT;
    rev_ok = 1'b1;
    case (prev_dir)
      odme_pkg::DIR_LEFT:  rev = odme_pkg::CODE_RIGHT;
      odme_pkg::DIR_UP:    rev = odme_pkg::CODE_DOWN;
      odme_pkg::DIR_RIGHT: rev = odme_pkg::CODE_LEFT;
      odme_pkg::DIR_DOWN:  rev = odme_pkg::CODE_UP;
      default:             rev_ok = 1'b0;
    endcase
  end

  // Enqueue the way back unless it is already held or the queue is full.
  always_comb begin
    found = 1'b0;
    for (int i = 0; i < 4; i++) begin
      if ((3'(i) < count) && (queue[2*i +: 2] == rev)) begin
        found = 1'b1;
      end
    end
    count_q = count;
    queue_q = queue;
    if (has_prev && rev_ok && !found && (count < odme_pkg::QUEUE_DEPTH)) begin
      queue_q[{count[1:0], 1'b0} +: 2] = rev;
      count_q = count + 3'd1;
    end
  end

  // Highest untried direction first.
  always_comb begin
    if (untried[3]) begin
      pick = odme_pkg::DIR_DOWN;
    end else if (untried[2]) begin
      pick = odme_pkg::DIR_RIGHT;
    end else if (untried[1]) begin
      pick = odme_pkg::DIR_UP;
    end else begin
      pick = odme_pkg::DIR_LEFT;
    end
  end

  // Choose a new direction, then a backtrack step, else report no solution.
  always_comb begin
    entry_out.visited = 1'b1;
    entry_out.untried = untried;
    entry_out.queue   = queue_q;
    entry_out.count   = count_q;
    decision.move     = odme_pkg::DIR_STOP;
    decision.status   = odme_pkg::STAT_NOSOL;
    decision.record   = 1'b0;
    if (untried != 4'd0) begin
      entry_out.untried = untried & ~pick;
      decision.move     = pick;
      decision.status   = odme_pkg::STAT_NEW;
      decision.record   = 1'b1;
    end else if (count_q != 3'd0) begin
      entry_out.queue = {2'b00, queue_q[7:2]};
      entry_out.count = count_q - 3'd1;
      decision.move   = 4'd1 << queue_q[1:0];
      decision.status = odme_pkg::STAT_BACK;
      decision.record = 1'b1;
    end
  end

endmodule

[rtl/online_dfs_maze_explorer.sv]
// Top level of the online depth-first maze explorer.
// Depends on odme_pkg, odme_ifs, odme_cell_update and the assertion macro header.
//
// Usage: each transfer on req carries the cell the agent stands in and its
// open-direction mask; exactly one transfer on rsp follows, carrying the chosen
// move and a status. The cfg channel writes the goal cell and is always ready;
// the user must write it only while no item is in flight, as the block does
// not enforce this.
// Flow: an item goes from IDLE to READ and then to UPDATE, where its result
// is registered; an item for the goal cell goes from IDLE straight to UPDATE.
// When CELLS is under 1024 the cell index is first reduced modulo CELLS in
// REDUCE by one shared reciprocal unit, quotient in the first step and
// remainder in the second, before READ. The per-cell table has a single
// write port; it is read in READ and written back in UPDATE, so items go one
// at a time; req is ready again in the cycle after the result is registered.
// Reset: a clearing pass writes every table word, one per cycle, and req stays
// low until the pass is done. The goal register resets to cell 1023.
// Stall: a result waits in the output register while rsp is not ready; the
// next item is taken meanwhile and holds in its last step until rsp is free.
module online_dfs_maze_explorer #(
  parameter int CELLS = 1024
) (
  input logic        clk,
  input logic        rst,
  odme_req_if.sink   req,
  odme_rsp_if.source rsp,
  odme_cfg_if.sink   cfg
);

`include "online_dfs_maze_explorer_assert.svh"

  localparam int AW = $clog2(CELLS);
  localparam bit NEED_MOD = CELLS < (1 << odme_pkg::CELL_W);
  localparam int RECIP_SH = odme_pkg::CELL_W + AW;
  localparam int RECIP = ((1 << RECIP_SH) + CELLS - 1) / CELLS;
  localparam logic [31:0] RECIP_C = 32'(RECIP);
  localparam logic [31:0] CELLS_C = 32'(CELLS);
  localparam logic [AW-1:0] LAST_ADDR = AW'(CELLS - 1);

  odme_pkg::state_t state, state_next;

  logic [odme_pkg::CELL_W-1:0] goal;
  logic [3:0]                  mask;
  logic                        is_goal;
  logic [AW-1:0]               idx;
  logic [odme_pkg::CELL_W-1:0] red_sh;
  logic                        red_step;
  logic [odme_pkg::CELL_W-1:0] red_quot;
  logic [31:0]                 red_q_full;
  logic [31:0]                 red_rem;
  logic [AW-1:0]               clr_addr;
  logic                        has_prev;
  logic [3:0]                  prev_dir;
  logic                        rsp_valid;
  logic [3:0]                  rsp_move;
  logic [1:0]                  rsp_status;
  logic                        rsp_is_move;
  logic                        req_fire;
  logic                        out_free;
  logic                        wr_en;
  logic                        finish;
  logic [AW-1:0]               wr_addr;
  odme_pkg::entry_t            wr_data;
  odme_pkg::entry_t            rd_data;
  odme_pkg::entry_t            new_entry;
  odme_pkg::decision_t         decision;

  odme_pkg::entry_t table_mem [CELLS];

  // Handshake terms.
  assign req_fire = req.valid && req.ready;
  assign out_free = !rsp_valid || rsp.ready;
  assign finish   = (state == odme_pkg::S_UPDATE) && out_free;

  // Next-state logic of the sequencer.
  always_comb begin
    state_next = state;
    case (state)
      odme_pkg::S_CLEAR: begin
        if (clr_addr == LAST_ADDR) state_next = odme_pkg::S_IDLE;
      end
      odme_pkg::S_IDLE: begin
        if (req.valid) begin
          if (req.cell_req == goal) begin
            state_next = odme_pkg::S_UPDATE;
          end else if (NEED_MOD) begin
            state_next = odme_pkg::S_REDUCE;
          end else begin
            state_next = odme_pkg::S_READ;
          end
        end
      end
      odme_pkg::S_REDUCE: begin
        if (red_step) state_next = odme_pkg::S_READ;
      end
      odme_pkg::S_READ: begin
        state_next = odme_pkg::S_UPDATE;
      end
      odme_pkg::S_UPDATE: begin
        if (out_free) state_next = odme_pkg::S_IDLE;
      end
      default: begin
        state_next = odme_pkg::S_CLEAR;
      end
    endcase
  end

  // Sequencer outputs.
  always_comb begin
    req.ready = (state == odme_pkg::S_IDLE);
    cfg.ready = 1'b1;
    wr_en     = finish && !is_goal;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= odme_pkg::S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  // Goal register, written over the cfg channel.
  always_ff @(posedge clk) begin
    if (rst) begin
      goal <= odme_pkg::GOAL_RESET;
    end else if (cfg.valid) begin
      goal <= cfg.goal_cell;
    end
  end

  // Clearing pass address.
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_addr <= '0;
    end else if (state == odme_pkg::S_CLEAR) begin
      clr_addr <= clr_addr + AW'(1);
    end
  end

  // Shared reciprocal unit: quotient in the first step, remainder in the second.
  assign red_q_full = (32'(red_sh) * RECIP_C) >> RECIP_SH;
  assign red_rem    = 32'(red_sh) - 32'(red_quot) * CELLS_C;

  // Item capture and modulo reduction of the cell index.
  always_ff @(posedge clk) begin
    if (req_fire) begin
      mask     <= req.open_mask;
      is_goal  <= (req.cell_req == goal);
      red_sh   <= req.cell_req;
      red_step <= 1'b0;
      idx      <= NEED_MOD ? '0 : AW'(req.cell_req);
    end else if (state == odme_pkg::S_REDUCE) begin
      red_step <= 1'b1;
      if (!red_step) begin
        red_quot <= odme_pkg::CELL_W'(red_q_full);
      end else begin
        idx <= AW'(red_rem);
      end
    end
  end

  // Single write port shared by the clearing pass and the write-back.
  always_comb begin
    if (state == odme_pkg::S_CLEAR) begin
      wr_addr = clr_addr;
      wr_data = '0;
    end else begin
      wr_addr = idx;
      wr_data = new_entry;
    end
  end

  // Per-cell table with registered read.
  always_ff @(posedge clk) begin
    if ((state == odme_pkg::S_CLEAR) || wr_en) begin
      table_mem[wr_addr] <= wr_data;
    end
    rd_data <= table_mem[idx];
  end

  odme_cell_update u_update (
    .entry_in  (rd_data),
    .open_mask (mask),
    .has_prev  (has_prev),
    .prev_dir  (prev_dir),
    .entry_out (new_entry),
    .decision  (decision)
  );

  // Previous-move record; any stop clears it.
  always_ff @(posedge clk) begin
    if (rst) begin
      has_prev <= 1'b0;
      prev_dir <= odme_pkg::DIR_STOP;
    end else if (finish) begin
      if (is_goal) begin
        has_prev <= 1'b0;
      end else begin
        has_prev <= decision.record;
        if (decision.record) prev_dir <= decision.move;
      end
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (finish) begin
      rsp_valid <= 1'b1;
    end else if (rsp.ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (finish) begin
      if (is_goal) begin
        rsp_move   <= odme_pkg::DIR_STOP;
        rsp_status <= odme_pkg::STAT_GOAL;
      end else begin
        rsp_move   <= decision.move;
        rsp_status <= decision.status;
      end
    end
  end

  assign rsp.valid    = rsp_valid;
  assign rsp.move_dir = rsp_move;
  assign rsp.status   = rsp_status;

  // A result that moves the agent, as opposed to a stop.
  assign rsp_is_move = (rsp_status == odme_pkg::STAT_NEW) ||
                       (rsp_status == odme_pkg::STAT_BACK);

  // A move result carries exactly one direction; a stop result carries none.
  `ODME_ASSERT_SAME(a_move_onehot, rsp_valid && rsp_is_move, $onehot(rsp_move))
  `ODME_ASSERT_SAME(a_stop_zero, rsp_valid && !rsp_is_move, rsp_move == odme_pkg::DIR_STOP)
  // No item is taken during the clearing pass.
  `ODME_ASSERT_SAME(a_no_take_clear, state == odme_pkg::S_CLEAR, !req.ready)
  // One item at a time: ready drops right after a transfer.
  `ODME_ASSERT_NEXT(a_one_in_flight, req_fire, !req.ready)
  // A table write-back always produces a result.
  `ODME_ASSERT_NEXT(a_write_gives_rsp, wr_en, rsp_valid)

endmodule

[verif/tb_online_dfs_maze_explorer.sv]
`timescale 1ns / 100ps
// Self-checking testbench for online_dfs_maze_explorer: directed table, then random maze walks.
// Depends on odme_pkg, the odme_ifs channel interfaces and the explorer RTL.
module tb_online_dfs_maze_explorer;

  typedef struct packed {
    logic [3:0] move;
    logic [1:0] status;
  } move_rsp_t;

  typedef enum bit {ROW_ITEM, ROW_GOAL} row_kind_t;

  typedef struct {
    row_kind_t                   kind;
    logic [odme_pkg::CELL_W-1:0] cell_id;
    logic [3:0]                  mask;
    bit                          typed;
    logic [3:0]                  move;
    logic [1:0]                  status;
  } plan_row_t;

  localparam int NUM_CELLS = 1024;
  localparam int PLAN_ROWS = 25;
  localparam int WALK_ITEMS = 800;
  localparam int GRID = 8;

  logic clk = 1'b0;
  logic rst;

  odme_req_if req_ch ();
  odme_rsp_if rsp_ch ();
  odme_cfg_if cfg_ch ();

  online_dfs_maze_explorer #(
    .CELLS(NUM_CELLS)
  ) DUT (
    .clk(clk),
    .rst(rst),
    .req(req_ch),
    .rsp(rsp_ch),
    .cfg(cfg_ch)
  );

  // Shadow copy of the explorer tables and registers.
  bit                          seen_cell [NUM_CELLS];
  logic [3:0]                  untried_dirs [NUM_CELLS];
  logic [7:0]                  back_codes [NUM_CELLS];
  logic [2:0]                  back_depth [NUM_CELLS];
  logic [3:0]                  last_move;
  bit                          have_last_move;
  logic [odme_pkg::CELL_W-1:0] goal_reg;

  move_rsp_t   pending_moves [$];
  int          mismatches;
  int          status_seen [4];
  int          items_sent;
  int          goal_writes;
  int          burst_left;
  int          stall_mode = 0;
  int          stall_left = 0;
  plan_row_t   plan [PLAN_ROWS];

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Computes the move for one cell visit and updates the shadow tables.
  function automatic move_rsp_t explore_step(input logic [odme_pkg::CELL_W-1:0] cell_id,
                                             input logic [3:0] mask);
    move_rsp_t  res;
    logic [1:0] rev;
    bit         rev_ok;
    bit         found;
    int         depth;
    if (cell_id == goal_reg) begin
      have_last_move = 1'b0;
      res.move = odme_pkg::DIR_STOP;
      res.status = odme_pkg::STAT_GOAL;
      return res;
    end
    if (!seen_cell[cell_id]) begin
      seen_cell[cell_id] = 1'b1;
      untried_dirs[cell_id] = mask;
    end
    depth = (back_depth[cell_id] > odme_pkg::QUEUE_DEPTH) ? int'(odme_pkg::QUEUE_DEPTH)
                                                           : int'(back_depth[cell_id]);
    // The way back is the reverse of the move that brought the agent here.
    if (have_last_move) begin
      rev_ok = 1'b1;
      case (last_move)
        odme_pkg::DIR_LEFT: rev = odme_pkg::CODE_RIGHT;
        odme_pkg::DIR_UP: rev = odme_pkg::CODE_DOWN;
        odme_pkg::DIR_RIGHT: rev = odme_pkg::CODE_LEFT;
        odme_pkg::DIR_DOWN: rev = odme_pkg::CODE_UP;
        default: begin
          rev = odme_pkg::CODE_LEFT;
          rev_ok = 1'b0;
        end
      endcase
      found = 1'b0;
      for (int i = 0; i < depth; i++)
        if (back_codes[cell_id][2*i +: 2] == rev) found = 1'b1;
      if (rev_ok && !found && depth < int'(odme_pkg::QUEUE_DEPTH)) begin
        back_codes[cell_id][2*depth +: 2] = rev;
        depth++;
        back_depth[cell_id] = 3'(depth);
      end
    end
    if (untried_dirs[cell_id] != 4'd0) begin
      if (untried_dirs[cell_id] & odme_pkg::DIR_DOWN) res.move = odme_pkg::DIR_DOWN;
      else if (untried_dirs[cell_id] & odme_pkg::DIR_RIGHT) res.move = odme_pkg::DIR_RIGHT;
      else if (untried_dirs[cell_id] & odme_pkg::DIR_UP) res.move = odme_pkg::DIR_UP;
      else res.move = odme_pkg::DIR_LEFT;
      untried_dirs[cell_id] = untried_dirs[cell_id] & ~res.move;
      res.status = odme_pkg::STAT_NEW;
      last_move = res.move;
      have_last_move = 1'b1;
    end else if (depth > 0) begin
      res.move = odme_pkg::DIR_LEFT << back_codes[cell_id][1:0];
      back_codes[cell_id] = back_codes[cell_id] >> 2;
      back_depth[cell_id] = 3'(depth - 1);
      res.status = odme_pkg::STAT_BACK;
      last_move = res.move;
      have_last_move = 1'b1;
    end else begin
      res.move = odme_pkg::DIR_STOP;
      res.status = odme_pkg::STAT_NOSOL;
      have_last_move = 1'b0;
    end
    return res;
  endfunction

  // Sends one cell visit in bursts with random gaps and records the expected move.
  task automatic send_item(input logic [odme_pkg::CELL_W-1:0] cell_id,
                           input logic [3:0] mask,
                           input bit typed, input move_rsp_t typed_rsp,
                           output move_rsp_t predicted);
    if (burst_left <= 0) begin
      @(negedge clk);
      req_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(negedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
                                                : $urandom_range(1, 8);
    end
    burst_left--;
    @(negedge clk);
    req_ch.valid <= 1'b1;
    req_ch.cell_req <= cell_id;
    req_ch.open_mask <= mask;
    do @(posedge clk); while (!req_ch.ready);
    predicted = explore_step(cell_id, mask);
    pending_moves = {pending_moves, (typed ? typed_rsp : predicted)};
    items_sent++;
  endtask

  // Writes the goal register once every pending move has come back.
  task automatic write_goal(input logic [odme_pkg::CELL_W-1:0] goal);
    @(negedge clk);
    req_ch.valid <= 1'b0;
    while (pending_moves.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    @(negedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.goal_cell <= goal;
    do @(posedge clk); while (!cfg_ch.ready);
    goal_reg = goal;
    goal_writes++;
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
    burst_left = 0;
  endtask

  // Response backpressure: one of four random patterns, chosen anew when its count runs out.
  always @(negedge clk) begin
    if (stall_left <= 0) begin
      stall_mode <= $urandom_range(0, 3);
      stall_left <= $urandom_range(30, 200);
    end else begin
      stall_left <= stall_left - 1;
    end
    case (stall_mode)
      0: rsp_ch.ready <= 1'b1;
      1: rsp_ch.ready <= ($urandom_range(0, 3) != 0);
      2: rsp_ch.ready <= (stall_left % 5 == 0);
      default: rsp_ch.ready <= ($urandom_range(0, 9) == 0);
    endcase
  end

  // Compares every response transfer with the oldest expected move.
  always @(posedge clk) begin
    move_rsp_t exp_rsp;
    if (!rst && rsp_ch.valid && rsp_ch.ready) begin
      if (pending_moves.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%0t: unexpected response move=%h status=%0d", $realtime,
                   rsp_ch.move_dir, rsp_ch.status);
      end else begin
        exp_rsp = pending_moves.pop_front();
        status_seen[exp_rsp.status]++;
        if (rsp_ch.move_dir !== exp_rsp.move || rsp_ch.status !== exp_rsp.status) begin
          mismatches++;
          if (mismatches <= 10)
            $display("%0t: mismatch move exp=%h got=%h status exp=%0d got=%0d",
                     $realtime, exp_rsp.move, rsp_ch.move_dir, exp_rsp.status,
                     rsp_ch.status);
        end
      end
    end
  end

  // Overall time limit.
  initial begin
    #5000000;
    $display("Regression FAIL");
    $finish;
  end

  // Main stimulus: directed table first, then random maze walks and noise.
  initial begin
    move_rsp_t   got;
    move_rsp_t   typed_rsp;
    bit          open_e [GRID][GRID];
    bit          open_s [GRID][GRID];
    int          w, h, px, py, base, steps, pick;
    logic [3:0]  mask;
    logic [odme_pkg::CELL_W-1:0] cell_id;

    rst = 1'b1;
    req_ch.valid = 1'b0;
    req_ch.cell_req = '0;
    req_ch.open_mask = '0;
    cfg_ch.valid = 1'b0;
    cfg_ch.goal_cell = '0;
    mismatches = 0;
    items_sent = 0;
    goal_writes = 0;
    burst_left = 0;
    status_seen = '{0, 0, 0, 0};
    foreach (seen_cell[i]) begin
      seen_cell[i] = 1'b0;
      untried_dirs[i] = '0;
      back_codes[i] = '0;
      back_depth[i] = '0;
    end
    last_move = odme_pkg::DIR_STOP;
    have_last_move = 1'b0;
    goal_reg = odme_pkg::GOAL_RESET;

    // Goal at reset, dead ends, a queue filled with all four ways back,
    // duplicate returns, and the goal register at both extremes.
    plan = '{
      '{ROW_ITEM, 10'd1023, 4'hF, 1'b1, odme_pkg::DIR_STOP, odme_pkg::STAT_GOAL},
      '{ROW_ITEM, 10'd0,    4'h0, 1'b1, odme_pkg::DIR_STOP, odme_pkg::STAT_NOSOL},
      '{ROW_ITEM, 10'd0,    4'hF, 1'b1, odme_pkg::DIR_STOP, odme_pkg::STAT_NOSOL},
      '{ROW_ITEM, 10'd1,    4'hF, 1'b1, odme_pkg::DIR_DOWN, odme_pkg::STAT_NEW},
      '{ROW_ITEM, 10'd2,    4'h5, 1'b0, odme_pkg::DIR_STOP, odme_pkg::STAT_NEW},
      '{ROW_ITEM, 10'd2,    4'h0, 1'b0, odme_pkg::DIR_STOP, odme_pkg::STAT_NEW},
      '{ROW_ITEM, 10'd2,    4'h0, 1'b0, odme_pkg::DIR_STOP, odme_pkg::STAT_NEW},
      '{ROW_ITEM, 10'd2,    4'h0, 1'b0, odme_pkg::DIR_STOP, odme_pkg::STAT_NEW},
      '{ROW_ITEM, 10'd2,    4'h0, 1'b0, odme_pkg::DIR_STOP, odme_pkg::STAT_NEW},
      '{ROW_ITEM, 10'd2,    4'h0, 1'b0, odme_pkg::DIR_STOP, odme_pkg::STAT_NEW},
      '{ROW_ITEM, 10'd4,    4'hF, 1'b0, odme_pkg::DIR_STOP, odme_pkg::STAT_NEW},
      '{ROW_ITEM, 10'd4,    4'h0, 1'b0, odme_pkg::DIR_STOP, odme_pkg::STAT_NEW},
      '{ROW_ITEM, 10'd4,    4'h0, 1'b0, odme_pkg::DIR_STOP, odme_pkg::STAT_NEW},
      '{ROW_ITEM, 10'd4,    4'h0, 1'b0, odme_pkg::DIR_STOP, odme_pkg::STAT_NEW},
      '{ROW_ITEM, 10'd4,    4'h0, 1'b0, odme_pkg::DIR_STOP, odme_pkg::STAT_NEW},
      '{ROW_ITEM, 10'd4,    4'h0, 1'b0, odme_pkg::DIR_STOP, odme_pkg::STAT_NEW},
      '{ROW_GOAL, 10'd0,    4'h0, 1'b0, odme_pkg::DIR_STOP, odme_pkg::STAT_NEW},
      '{ROW_ITEM, 10'd0,    4'hF, 1'b1, odme_pkg::DIR_STOP, odme_pkg::STAT_GOAL},
      '{ROW_ITEM, 10'd1023, 4'hA, 1'b1, odme_pkg::DIR_DOWN, odme_pkg::STAT_NEW},
      '{ROW_ITEM, 10'd1023, 4'h0, 1'b0, odme_pkg::DIR_STOP, odme_pkg::STAT_NEW},
      '{ROW_GOAL, 10'd1023, 4'h0, 1'b0, odme_pkg::DIR_STOP, odme_pkg::STAT_NEW},
      '{ROW_ITEM, 10'd1023, 4'h0, 1'b1, odme_pkg::DIR_STOP, odme_pkg::STAT_GOAL},
      '{ROW_ITEM, 10'd512,  4'h8, 1'b1, odme_pkg::DIR_DOWN, odme_pkg::STAT_NEW},
      '{ROW_ITEM, 10'd512,  4'h1, 1'b0, odme_pkg::DIR_STOP, odme_pkg::STAT_NEW},
      '{ROW_ITEM, 10'd700,  4'hF, 1'b0, odme_pkg::DIR_STOP, odme_pkg::STAT_NEW}
    };

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (plan[i]) begin
      if (plan[i].kind == ROW_GOAL) begin
        write_goal(plan[i].cell_id);
      end else begin
        typed_rsp.move = plan[i].move;
        typed_rsp.status = plan[i].status;
        send_item(plan[i].cell_id, plan[i].mask, plan[i].typed, typed_rsp, got);
      end
    end

    // Random part: depth-first walks through random mazes in 8x8 regions.
    typed_rsp = '0;
    while (items_sent < PLAN_ROWS + WALK_ITEMS) begin
      if ($urandom_range(0, 7) == 0) begin
        // Noise burst of unrelated cells.
        repeat ($urandom_range(10, 30)) begin
          cell_id = ($urandom_range(0, 9) == 0) ? goal_reg
                                                : odme_pkg::CELL_W'($urandom_range(0, 1023));
          send_item(cell_id, 4'($urandom_range(0, 15)), 1'b0, typed_rsp, got);
        end
      end else begin
        w = $urandom_range(1, GRID);
        h = $urandom_range(1, GRID);
        base = $urandom_range(0, NUM_CELLS / (GRID * GRID) - 1) * GRID * GRID;
        foreach (open_e[y, x]) begin
          open_e[y][x] = ($urandom_range(0, 9) < 7);
          open_s[y][x] = ($urandom_range(0, 9) < 7);
        end
        if ($urandom_range(0, 1) == 0) begin
          pick = $urandom_range(0, 3);
          case (pick)
            0: write_goal(odme_pkg::CELL_W'(base + $urandom_range(0, h - 1) * GRID
                                            + $urandom_range(0, w - 1)));
            1: write_goal(10'd1023);
            2: write_goal(10'd0);
            default: write_goal(odme_pkg::CELL_W'($urandom_range(0, 1023)));
          endcase
        end
        px = $urandom_range(0, w - 1);
        py = $urandom_range(0, h - 1);
        steps = 0;
        got.move = odme_pkg::DIR_LEFT;
        while (got.move != odme_pkg::DIR_STOP && steps < 300) begin
          if ($urandom_range(0, 19) == 0)
            send_item(odme_pkg::CELL_W'($urandom_range(0, 1023)),
                      4'($urandom_range(0, 15)), 1'b0, typed_rsp, got);
          mask[0] = (px > 0) ? open_e[py][px-1] : 1'b0;
          mask[1] = (py > 0) ? open_s[py-1][px] : 1'b0;
          mask[2] = (px < w - 1) ? open_e[py][px] : 1'b0;
          mask[3] = (py < h - 1) ? open_s[py][px] : 1'b0;
          send_item(odme_pkg::CELL_W'(base + py * GRID + px), mask, 1'b0, typed_rsp, got);
          steps++;
          case (got.move)
            odme_pkg::DIR_DOWN: if (py < h - 1) py++;
            odme_pkg::DIR_UP: if (py > 0) py--;
            odme_pkg::DIR_RIGHT: if (px < w - 1) px++;
            odme_pkg::DIR_LEFT: if (px > 0) px--;
            default: ;
          endcase
        end
      end
    end

    // Drain all outstanding moves, then wait for any stray responses.
    @(negedge clk);
    req_ch.valid <= 1'b0;
    while (pending_moves.size() != 0) @(posedge clk);
    repeat (30) @(posedge clk);

    $display("Sent %0d cell visits with %0d goal writes.", items_sent, goal_writes);
    $display("Moves: %0d new, %0d backtrack, %0d goal, %0d no solution.",
             status_seen[odme_pkg::STAT_NEW], status_seen[odme_pkg::STAT_BACK],
             status_seen[odme_pkg::STAT_GOAL], status_seen[odme_pkg::STAT_NOSOL]);
    if (mismatches == 0 && pending_moves.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
